// ===== hw/rtl/polyphonic_plucked_string_synth_core_macros.svh =====
// Assertion macros for the plucked-string synth core.
`ifndef POLYPHONIC_PLUCKED_STRING_SYNTH_CORE_MACROS_SVH
`define POLYPHONIC_PLUCKED_STRING_SYNTH_CORE_MACROS_SVH

// Checked at every clock edge outside reset.
`define PPSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define PPSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/ppss_pkg.sv =====
// Package: constants, register indexes and build-time tables of the synth core.
package ppss_pkg;

  localparam int unsigned Voices     = 24;
  localparam int unsigned MaxDelay   = 4096;
  localparam int unsigned SampleRate = 44100;
  localparam int unsigned SampleBits = 16;

  localparam int unsigned OutW    = 21;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NoteW   = 7;
  localparam int unsigned VqW     = 17;  // Q0.16 up to 1.0
  localparam int unsigned LenTabW = 15;  // holds lengths up to the largest delay

  localparam logic [CfgIdxW-1:0] RegSustain = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDamping = 2'd1;

  localparam logic [CfgW-1:0] SustainReset = 16'd64881;
  localparam logic [CfgW-1:0] DampingReset = 16'd6554;

  localparam logic [31:0] LfsrSeed = 32'h2545_F491;
  localparam logic [31:0] LfsrMask = 32'h8020_0003;

  localparam int unsigned VelDiv   = 127;
  localparam int unsigned Semis    = 12;
  localparam int unsigned BaseFreq = 440;

  typedef logic [127:0][LenTabW-1:0] len_tab_t;
  typedef logic [127:0][VqW-1:0]     vq_tab_t;

  // 2^(s/12) in Q16
  function automatic logic [16:0] semitone_q16(input int unsigned s);
    logic [16:0] r;
    case (s)
      0:       r = 17'd65536;
      1:       r = 17'd69433;
      2:       r = 17'd73562;
      3:       r = 17'd77936;
      4:       r = 17'd82570;
      5:       r = 17'd87480;
      6:       r = 17'd92682;
      7:       r = 17'd98193;
      8:       r = 17'd104032;
      9:       r = 17'd110218;
      10:      r = 17'd116772;
      default: r = 17'd123715;
    endcase
    return r;
  endfunction

  // Delay length per note, evaluated at elaboration (shift-subtract long division).
  function automatic len_tab_t note_len_tab(input int unsigned rate, input int unsigned maxd);
    len_tab_t    tab;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    int unsigned q;
    int unsigned s;
    tab = '0;
    for (int n = 0; n < 128; n++) begin
      q = n / Semis;
      s = n % Semis + 3;
      if (s >= Semis) begin
        s = s - Semis;
        q = q + 1;
      end
      num = 64'(rate) << 22;
      den = (64'(BaseFreq) * 64'(semitone_q16(s))) << q;
      rem = '0;
      quo = '0;
      for (int k = 63; k >= 0; k--) begin
        rem = {rem[62:0], num[k]};
        if (rem >= den) begin
          rem = rem - den;
          quo[k] = 1'b1;
        end
      end
      if (quo > 64'(maxd)) quo = 64'(maxd);
      if (quo < 64'd1) quo = 64'd1;
      tab[n] = quo[LenTabW-1:0];
    end
    return tab;
  endfunction

  // Velocity to Q0.16 gain, rounded as (vel*65536 + 63) / 127.
  function automatic vq_tab_t vel_tab();
    vq_tab_t     tab;
    logic [31:0] t;
    for (int v = 0; v < 128; v++) begin
      t = (32'(v) * 32'd65536 + 32'd63) / VelDiv;
      tab[v] = t[VqW-1:0];
    end
    return tab;
  endfunction

endpackage

// ===== hw/rtl/polyphonic_plucked_string_synth_core.sv =====
// Top level: polyphonic plucked-string synth with a shared multiplier and sequencer.
//
//  channel | direction | handshake                  | payload
//  in      | sink      | in_valid_i / in_stall_o    | mode_i, note_i, velocity_i
//  out     | source    | out_valid_o / out_stall_i  | sample_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// After reset the delay memory is swept to zero, one entry per cycle, with in_stall_o
// high; cfg writes are taken throughout. Tick: every voice is visited in turn; each active
// voice is read, filtered and written back (one shared multiplier, one memory read port).
// Note on: a scan for a free voice, or the oldest when all are busy, the wrap remainder by
// shift-subtract, then the fill of each sample. Note off: a scan of every voice.
// A finished sample sits in the output register; a stalled output holds the next tick.
`include "polyphonic_plucked_string_synth_core_macros.svh"

module polyphonic_plucked_string_synth_core #(
  parameter int unsigned VOICES      = ppss_pkg::Voices,
  parameter int unsigned MAX_DELAY   = ppss_pkg::MaxDelay,
  parameter int unsigned SAMPLE_RATE = ppss_pkg::SampleRate,
  parameter int unsigned SAMPLE_BITS = ppss_pkg::SampleBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [ppss_pkg::NoteW-1:0]      note_i,
  input  logic [ppss_pkg::NoteW-1:0]      velocity_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ppss_pkg::OutW-1:0] sample_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ppss_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ppss_pkg::CfgW-1:0]       cfg_data_i
);

  localparam int unsigned Depth = VOICES * MAX_DELAY;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW    = $clog2(VOICES + 1);
  localparam int unsigned PW    = $clog2(MAX_DELAY);
  localparam int unsigned LW    = $clog2(MAX_DELAY + 1);
  localparam int unsigned MCW   = $clog2(PW + 2);
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned MW    = (SB + 2 > 18) ? SB + 2 : 18;
  localparam int unsigned SW    = SB + $clog2(VOICES + 1) + 1;
  localparam int unsigned VqW   = ppss_pkg::VqW;

  localparam ppss_pkg::len_tab_t LenTab = ppss_pkg::note_len_tab(SAMPLE_RATE, MAX_DELAY);
  localparam ppss_pkg::vq_tab_t  VqTab  = ppss_pkg::vel_tab();

  localparam logic signed [MW-1:0] SmpMax = MW'((1 << (SB - 1)) - 1);
  localparam logic signed [MW-1:0] SmpMin = -SmpMax - MW'(1);
  localparam logic signed [SW-1:0] OutMax = SW'((1 << (ppss_pkg::OutW - 1)) - 1);
  localparam logic signed [SW-1:0] OutMin = -OutMax - SW'(1);
  localparam logic [VqW-1:0]       One    = VqW'(65536);

  typedef enum logic [16:0] {
    S_CLR  = 17'h00001,
    S_IDLE = 17'h00002,
    S_PICK = 17'h00004,
    S_MOD  = 17'h00008,
    S_F0   = 17'h00010,
    S_F1   = 17'h00020,
    S_F2   = 17'h00040,
    S_F3   = 17'h00080,
    S_OFF  = 17'h00100,
    S_TRD  = 17'h00200,
    S_TRP  = 17'h00400,
    S_TM1  = 17'h00800,
    S_TM2  = 17'h01000,
    S_TAD  = 17'h02000,
    S_TM3  = 17'h04000,
    S_TWR  = 17'h08000,
    S_OUT  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [ppss_pkg::CfgW-1:0] sus_q, damp_q;

  // captured item
  logic                      mode_q;
  logic [ppss_pkg::NoteW-1:0] note_q, vel_q;

  // per-voice state
  logic [VOICES-1:0]          act_q;
  logic [ppss_pkg::NoteW-1:0] vnote_q [VOICES];
  logic [LW-1:0]              vlen_q  [VOICES];
  logic [PW-1:0]              vpos_q  [VOICES];
  logic [PW-1:0]              vnext_q [VOICES];
  logic [31:0]                vstamp_q[VOICES];

  logic [31:0] press_q;
  logic [CW-1:0] act_cnt_q;
  logic [31:0] lfsr_q, lfsr_d;

  // sequencer datapath
  logic [VW-1:0]  idx_q;
  logic [VW-1:0]  best_q;
  logic [31:0]    best_stamp_q;
  logic [CW-1:0]  cnt_q;
  logic [AW-1:0]  clr_q;
  logic [PW:0]    modx_q;
  logic [LW-1:0]  rem_q;
  logic [MCW-1:0] mcnt_q;
  logic [PW-1:0]  fi_q;
  logic signed [MW-1:0] prev_q, tmp_q, mix_q, res_q, c_q;
  logic signed [SW-1:0] sum_q;
  logic signed [ppss_pkg::OutW-1:0] out_q;
  logic out_valid_q;

  // memory
  logic [SB-1:0] mem [Depth];
  logic [SB-1:0] rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [SB-1:0] wdata;

  // shared multiplier
  logic signed [MW-1:0]    ma;
  logic [VqW-1:0]          mb;
  logic signed [MW+17:0]   prod, rnd;

  logic                 last_v, full, in_acc, out_load;
  logic [AW-1:0]        base;
  logic [LW-1:0]        cur_len, new_len;
  logic [PW-1:0]        cur_pos, cur_next, wrap_next;
  logic [VqW-1:0]       vq;
  logic signed [MW-1:0] noise, rd_ext, fill_x, fill_sat, res_sat;
  logic [LW:0]          r2;
  logic signed [SW-1:0] sum_sat;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q;

  assign last_v   = (idx_q == VW'(VOICES - 1));
  assign full     = (act_cnt_q >= CW'(VOICES));
  assign base     = AW'(idx_q) * AW'(MAX_DELAY);
  assign cur_len  = vlen_q[idx_q];
  assign cur_pos  = vpos_q[idx_q];
  assign cur_next = vnext_q[idx_q];
  assign new_len  = LenTab[note_q][LW-1:0];
  assign vq       = VqTab[vel_q];
  assign wrap_next = ((LW'(cur_next) + LW'(1)) == cur_len) ? '0 : cur_next + PW'(1);
  assign r2       = {rem_q, modx_q[PW]};
  assign rd_ext   = MW'($signed(rdata_q));

  // LFSR step and noise in Q1.15, [-0.5, 0.5)
  always_comb begin
    lfsr_d = lfsr_q >> 1;
    if (lfsr_q[0]) lfsr_d = lfsr_d ^ ppss_pkg::LfsrMask;
  end
  assign noise = MW'($signed({~lfsr_d[31], ~lfsr_d[31], lfsr_d[30:17]}));

  always_comb begin
    ma = c_q;
    mb = One - VqW'(damp_q);
    unique case (state_q)
      S_F0:    begin ma = noise;  mb = vq; end
      S_F1:    begin ma = res_q;  mb = vq; end
      S_F2:    begin ma = prev_q; mb = One - vq; end
      S_TM1:   begin ma = c_q;    mb = One - VqW'(damp_q); end
      S_TM2:   begin ma = rd_ext; mb = VqW'(damp_q); end
      S_TM3:   begin ma = mix_q;  mb = VqW'(sus_q); end
      default: begin ma = c_q;    mb = One - VqW'(damp_q); end
    endcase
  end
  assign prod = ma * $signed({1'b0, mb});
  assign rnd  = prod + (MW+18)'(32768);

  assign fill_x = tmp_q + res_q;
  always_comb begin
    fill_sat = fill_x;
    if (fill_x > SmpMax) fill_sat = SmpMax;
    else if (fill_x < SmpMin) fill_sat = SmpMin;
    res_sat = res_q;
    if (res_q > SmpMax) res_sat = SmpMax;
    else if (res_q < SmpMin) res_sat = SmpMin;
    sum_sat = sum_q;
    if (sum_q > OutMax) sum_sat = OutMax;
    else if (sum_q < OutMin) sum_sat = OutMin;
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    re    = 1'b0;
    raddr = base + AW'(cur_next);
    unique case (state_q)
      S_CLR: we = 1'b1;
      S_F3: begin
        we    = 1'b1;
        waddr = base + AW'(fi_q);
        wdata = fill_sat[SB-1:0];
      end
      S_TRD: re = act_q[idx_q];
      S_TRP: begin
        re    = 1'b1;
        raddr = base + AW'(cur_pos);
      end
      S_TWR: begin
        we    = 1'b1;
        waddr = base + AW'(cur_next);
        wdata = res_sat[SB-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      S_IDLE: if (in_acc) begin
        if (!mode_i) state_d = S_TRD;
        else if (velocity_i != '0) state_d = S_PICK;
        else state_d = S_OFF;
      end
      S_PICK: if (full ? last_v : !act_q[idx_q]) state_d = S_MOD;
      S_MOD:  if (mcnt_q == MCW'(PW + 1)) state_d = S_F0;
      S_F0:   state_d = S_F1;
      S_F1:   state_d = S_F2;
      S_F2:   state_d = S_F3;
      S_F3:   state_d = ((LW'(fi_q) + LW'(1)) == new_len) ? S_IDLE : S_F0;
      S_OFF:  if (last_v) state_d = S_IDLE;
      S_TRD:  if (act_q[idx_q]) state_d = S_TRP;
              else if (last_v) state_d = S_OUT;
      S_TRP:  state_d = S_TM1;
      S_TM1:  state_d = S_TM2;
      S_TM2:  state_d = S_TAD;
      S_TAD:  state_d = S_TM3;
      S_TM3:  state_d = S_TWR;
      S_TWR:  state_d = last_v ? S_OUT : S_TRD;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      sus_q       <= ppss_pkg::SustainReset;
      damp_q      <= ppss_pkg::DampingReset;
      act_q       <= '0;
      press_q     <= '0;
      act_cnt_q   <= '0;
      lfsr_q      <= ppss_pkg::LfsrSeed;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      mcnt_q      <= '0;
      for (int v = 0; v < VOICES; v++) begin
        vnote_q[v]  <= '0;
        vpos_q[v]   <= '0;
        vstamp_q[v] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          ppss_pkg::RegSustain: sus_q  <= cfg_data_i;
          ppss_pkg::RegDamping: damp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;

      unique case (state_q)
        S_CLR:  clr_q <= clr_q + AW'(1);
        S_IDLE: begin
          idx_q  <= '0;
          mcnt_q <= '0;
        end
        S_PICK: begin
          if (full) begin
            if (last_v) begin
              idx_q <= (idx_q == '0 || vstamp_q[idx_q] < best_stamp_q) ? idx_q : best_q;
            end else begin
              idx_q <= idx_q + VW'(1);
            end
          end else if (act_q[idx_q]) begin
            idx_q <= idx_q + VW'(1);
          end
        end
        S_MOD: mcnt_q <= mcnt_q + MCW'(1);
        S_F0:  lfsr_q <= lfsr_d;
        S_F3: if ((LW'(fi_q) + LW'(1)) == new_len) begin
          vnote_q[idx_q]  <= note_q;
          act_q[idx_q]    <= 1'b1;
          vstamp_q[idx_q] <= press_q + 32'd1;
          press_q         <= press_q + 32'd1;
          if (!full) act_cnt_q <= act_cnt_q + CW'(1);
        end
        S_OFF: begin
          if (vnote_q[idx_q] == note_q) act_q[idx_q] <= 1'b0;
          if (last_v) begin
            act_cnt_q <= cnt_q + CW'(act_q[idx_q] && (vnote_q[idx_q] != note_q));
          end else begin
            idx_q <= idx_q + VW'(1);
          end
        end
        S_TRD: if (!act_q[idx_q] && !last_v) idx_q <= idx_q + VW'(1);
        S_TWR: begin
          vpos_q[idx_q] <= cur_next;
          if (!last_v) idx_q <= idx_q + VW'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    res_q <= rnd[16 +: MW];
    if (in_acc) begin
      mode_q <= mode_i;
      note_q <= note_i;
      vel_q  <= velocity_i;
      sum_q  <= '0;
      cnt_q  <= '0;
    end
    if (out_load) out_q <= sum_sat[ppss_pkg::OutW-1:0];
    unique case (state_q)
      S_PICK: if (idx_q == '0 || vstamp_q[idx_q] < best_stamp_q) begin
        best_q       <= idx_q;
        best_stamp_q <= vstamp_q[idx_q];
      end
      S_MOD: begin
        if (mcnt_q == '0) begin
          modx_q <= (PW+1)'(cur_pos) + (PW+1)'(1);
          rem_q  <= '0;
        end else begin
          modx_q <= modx_q << 1;
          rem_q  <= (r2 >= (LW+1)'(new_len)) ? LW'(r2 - (LW+1)'(new_len)) : LW'(r2);
        end
        fi_q   <= '0;
        prev_q <= '0;
      end
      S_F2: tmp_q <= res_q;
      S_F3: begin
        prev_q <= fill_sat;
        fi_q   <= fi_q + PW'(1);
        if ((LW'(fi_q) + LW'(1)) == new_len) begin
          vlen_q[idx_q]  <= new_len;
          vnext_q[idx_q] <= rem_q[PW-1:0];
        end
      end
      S_OFF: if (act_q[idx_q] && (vnote_q[idx_q] != note_q)) cnt_q <= cnt_q + CW'(1);
      S_TRP: c_q   <= rd_ext;
      S_TM2: tmp_q <= res_q;
      S_TAD: mix_q <= tmp_q + res_q;
      S_TWR: begin
        vnext_q[idx_q] <= wrap_next;
        sum_q          <= sum_q + SW'(c_q);
      end
      default: ;
    endcase
  end

  `PPSS_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == S_OUT),
               "output loaded outside the output step")
  `PPSS_ASSERT(a_tick_in_line, (state_q == S_TWR) |-> (LW'(cur_next) < cur_len),
               "tick write beyond the voice delay length")
  `PPSS_ASSERT(a_mod_in_range,
               (state_q == S_F0 && $past(state_q == S_MOD)) |-> (rem_q < new_len),
               "wrap remainder not below the new length")
  `PPSS_ASSERT(a_fill_in_line, (state_q == S_F3) |-> (LW'(fi_q) < new_len),
               "fill index beyond the new length")
  `PPSS_ASSERT(a_tick_no_strike, (state_q == S_TRD) |-> !mode_q,
               "tick sequence entered for a note message")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the plucked-string synth core: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int NV   = ppss_pkg::Voices;
  localparam int MAXD = ppss_pkg::MaxDelay;
  localparam int SMAX = (1 << (ppss_pkg::SampleBits - 1)) - 1;
  localparam int SMIN = -SMAX - 1;
  localparam longint OMAX = 1048575;
  localparam longint OMIN = -1048576;
  localparam int HOLD_CYCLES = 3000;

  // indexes with no register behind them
  localparam logic [ppss_pkg::CfgIdxW-1:0] RegUnusedLo = 2'd2;
  localparam logic [ppss_pkg::CfgIdxW-1:0] RegUnusedHi = 2'd3;

  localparam int unsigned STEP_Q16 [12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                            92682, 98193, 104032, 110218, 116772, 123715};

  typedef enum logic {MODE_TICK = 1'b0, MODE_NOTE = 1'b1} mode_e;

  typedef struct {
    mode_e                             mode;
    logic [ppss_pkg::NoteW-1:0]        note;
    logic [ppss_pkg::NoteW-1:0]        vel;
    bit                                fixed;   // sample typed in below, not predicted
    logic signed [ppss_pkg::OutW-1:0]  sample;
  } stim_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              mode_i = 1'b0;
  logic [ppss_pkg::NoteW-1:0]        note_i = '0;
  logic [ppss_pkg::NoteW-1:0]        velocity_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [ppss_pkg::OutW-1:0]  sample_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [ppss_pkg::CfgIdxW-1:0]      cfg_index_i = '0;
  logic [ppss_pkg::CfgW-1:0]         cfg_data_i = '0;

  polyphonic_plucked_string_synth_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------- predictor state ----------------
  int          string_mem [NV*MAXD];
  bit          v_active [NV];
  int unsigned v_note [NV];
  int unsigned v_len [NV];
  int unsigned v_pos [NV];
  int unsigned v_stamp [NV];
  int unsigned strike_count;
  int unsigned busy_count;
  logic [31:0] noise_reg;
  int unsigned sustain_q16;
  int unsigned damping_q16;

  logic signed [ppss_pkg::OutW-1:0] sample_q [$];
  stim_row_t                        item_q [$];
  int                               errors = 0;

  function automatic longint qmul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic int clip_sample(longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return int'(x);
  endfunction

  function automatic int unsigned string_length(int unsigned n);
    int unsigned q, s;
    longint unsigned num, den, len;
    q = n / 12;
    s = n % 12 + 3;
    if (s >= 12) begin
      s -= 12;
      q += 1;
    end
    num = longint'(ppss_pkg::SampleRate) << 22;
    den = (64'd440 * STEP_Q16[s]) << q;
    len = num / den;
    if (len > MAXD) len = MAXD;
    if (len < 1) len = 1;
    return int'(len);
  endfunction

  function automatic int noise_step();
    bit lsb;
    lsb = noise_reg[0];
    noise_reg = noise_reg >> 1;
    if (lsb) noise_reg = noise_reg ^ ppss_pkg::LfsrMask;
    return int'(noise_reg >> 17) - 16384;
  endfunction

  function automatic void pluck(int v, int unsigned n, int unsigned vel);
    longint vq, prev, x;
    int unsigned len;
    vq = (longint'(vel) * 65536 + 63) / 127;
    len = string_length(n);
    prev = 0;
    v_note[v] = n;
    v_active[v] = 1'b1;
    v_len[v] = len;
    for (int i = 0; i < len; i++) begin
      x = qmul(qmul(noise_step(), vq), vq) + qmul(prev, 65536 - vq);
      x = clip_sample(x);
      string_mem[v*MAXD + i] = int'(x);
      prev = x;
    end
    strike_count += 1;
    v_stamp[v] = strike_count;
  endfunction

  function automatic void reset_model();
    foreach (string_mem[i]) string_mem[i] = 0;
    for (int v = 0; v < NV; v++) begin
      v_active[v] = 0;
      v_note[v] = 0;
      v_len[v] = 1;
      v_pos[v] = 0;
      v_stamp[v] = 0;
    end
    strike_count = 0;
    busy_count = 0;
    noise_reg = ppss_pkg::LfsrSeed;
    sustain_q16 = ppss_pkg::SustainReset;
    damping_q16 = ppss_pkg::DampingReset;
  endfunction

  // Updates state for one accepted item; a tick queues its expected sample.
  function automatic void synth_step(stim_row_t it);
    int best, cnt;
    int unsigned len, p, pos;
    longint sum, c, mix;
    if (it.mode == MODE_NOTE) begin
      if (it.vel != 0) begin
        if (busy_count >= NV) begin
          best = 0;
          for (int v = 1; v < NV; v++)
            if (v_stamp[v] < v_stamp[best]) best = v;
          pluck(best, it.note, it.vel);
        end else begin
          for (int v = 0; v < NV; v++) begin
            if (!v_active[v]) begin
              pluck(v, it.note, it.vel);
              busy_count++;
              break;
            end
          end
        end
      end else begin
        cnt = 0;
        for (int v = 0; v < NV; v++) begin
          if (v_note[v] == it.note) v_active[v] = 0;
          if (v_active[v]) cnt++;
        end
        busy_count = cnt;
      end
    end else begin
      sum = 0;
      for (int v = 0; v < NV; v++) begin
        if (!v_active[v]) continue;
        len = v_len[v];
        if (len < 1 || len > MAXD) len = 1;
        p = v_pos[v] % MAXD;
        pos = (p + 1) % len;
        c = string_mem[v*MAXD + pos];
        mix = qmul(c, 65536 - damping_q16) + qmul(string_mem[v*MAXD + p], damping_q16);
        string_mem[v*MAXD + pos] = clip_sample(qmul(mix, sustain_q16));
        v_pos[v] = pos;
        sum += c;
      end
      if (sum > OMAX) sum = OMAX;
      if (sum < OMIN) sum = OMIN;
      sample_q.insert(sample_q.size(), it.fixed ? it.sample : ppss_pkg::OutW'(sum));
    end
  endfunction

  // ---------------- input side: bursts and gaps ----------------
  stim_row_t cur_item;
  int        gap_left = 0;
  int        burst_left = 1;
  bit        took;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) synth_step(cur_item);
      if (!in_valid_i || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (item_q.size() > 0) begin
          cur_item = item_q.pop_front();
          mode_i     <= cur_item.mode;
          note_i     <= cur_item.note;
          velocity_i <= cur_item.vel;
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- output side: stall pattern and check ----------------
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_run = 0;
  int stall_kind = 0;
  logic signed [ppss_pkg::OutW-1:0] want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sample_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample transfer: %0d", sample_o);
      end else begin
        want = sample_q.pop_front();
        if (sample_o !== want) begin
          errors++;
          if (errors <= 10)
            $display("sample mismatch: expected %0d, got %0d", want, sample_o);
        end
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_run = $urandom_range(1, 40);
        stall_kind = $urandom_range(0, 3);
      end
      stall_run--;
      case (stall_kind)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= 1'b1;
        end
        default: begin
          out_stall_i <= 1'($urandom_range(0, 1));
        end
      endcase
    end
  end

  // ---------------- helpers ----------------
  task automatic write_reg(logic [ppss_pkg::CfgIdxW-1:0] idx, logic [ppss_pkg::CfgW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == ppss_pkg::RegSustain) sustain_q16 = data;
    else if (idx == ppss_pkg::RegDamping) damping_q16 = data;
    cfg_valid_i <= 1'b0;
  endtask

  // A trailing tick ensures any note work has finished before its sample returns.
  task automatic drain();
    stim_row_t t;
    t = '{MODE_TICK, '0, '0, 1'b0, '0};
    item_q.insert(item_q.size(), t);
    do @(posedge clk_i); while (item_q.size() != 0 || in_valid_i || sample_q.size() != 0);
  endtask

  function automatic stim_row_t random_item();
    stim_row_t t;
    int r, held [$];
    r = $urandom_range(0, 99);
    t = '{MODE_TICK, ppss_pkg::NoteW'($urandom), '0, 1'b0, '0};
    if (r < 55) begin
      t.mode = MODE_TICK;
    end else if (r < 88) begin
      t.mode = MODE_NOTE;
      // low notes mean long strings and slow fills, so keep them rare
      t.note = ppss_pkg::NoteW'(($urandom_range(0, 49) == 0) ? $urandom_range(0, 47)
                                                              : $urandom_range(48, 127));
      case ($urandom_range(0, 9))
        0: t.vel = ppss_pkg::NoteW'(1);
        1: t.vel = ppss_pkg::NoteW'(127);
        default: t.vel = ppss_pkg::NoteW'($urandom_range(1, 127));
      endcase
    end else begin
      t.mode = MODE_NOTE;
      t.vel = '0;
      for (int v = 0; v < NV; v++) if (v_active[v]) held.insert(held.size(), int'(v_note[v]));
      if (held.size() > 0 && $urandom_range(0, 9) < 7)
        t.note = ppss_pkg::NoteW'(held[$urandom_range(0, held.size() - 1)]);
      else
        t.note = ppss_pkg::NoteW'($urandom_range(0, 127));
    end
    return t;
  endfunction

  stim_row_t directed_rows [20] = '{
    '{MODE_TICK, 7'd0,   7'd0,   1'b1, 21'sd0},   // nothing struck yet
    '{MODE_NOTE, 7'd127, 7'd127, 1'b0, 21'sd0},
    '{MODE_TICK, 7'd0,   7'd0,   1'b0, 21'sd0},
    '{MODE_TICK, 7'd0,   7'd0,   1'b0, 21'sd0},
    '{MODE_NOTE, 7'd0,   7'd127, 1'b0, 21'sd0},   // longest string
    '{MODE_TICK, 7'd0,   7'd0,   1'b0, 21'sd0},
    '{MODE_NOTE, 7'd0,   7'd0,   1'b0, 21'sd0},
    '{MODE_NOTE, 7'd127, 7'd0,   1'b0, 21'sd0},
    '{MODE_TICK, 7'd0,   7'd0,   1'b1, 21'sd0},   // all released
    '{MODE_NOTE, 7'd5,   7'd0,   1'b0, 21'sd0},   // release of a note not held
    '{MODE_TICK, 7'd0,   7'd0,   1'b1, 21'sd0},
    '{MODE_NOTE, 7'd69,  7'd1,   1'b0, 21'sd0},
    '{MODE_TICK, 7'd0,   7'd0,   1'b0, 21'sd0},
    '{MODE_NOTE, 7'd100, 7'd64,  1'b0, 21'sd0},   // restrike keeps old position
    '{MODE_TICK, 7'd0,   7'd0,   1'b0, 21'sd0},
    '{MODE_NOTE, 7'd85,  7'd127, 1'b0, 21'sd0},
    '{MODE_TICK, 7'd0,   7'd0,   1'b0, 21'sd0},
    '{MODE_NOTE, 7'd69,  7'd0,   1'b0, 21'sd0},
    '{MODE_TICK, 7'd0,   7'd0,   1'b0, 21'sd0},
    '{MODE_TICK, 7'd0,   7'd0,   1'b0, 21'sd0}
  };

  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(ppss_pkg::RegSustain, ppss_pkg::SustainReset);
    write_reg(ppss_pkg::RegDamping, ppss_pkg::DampingReset);
    foreach (directed_rows[i]) item_q.insert(item_q.size(), directed_rows[i]);
    drain();

    for (int seg = 0; seg < 12; seg++) begin
      case (seg)
        0: begin
          write_reg(ppss_pkg::RegSustain, 16'hFFFF);
          write_reg(ppss_pkg::RegDamping, 16'h0000);
        end
        1: begin
          write_reg(ppss_pkg::RegSustain, 16'h0000);
          write_reg(ppss_pkg::RegDamping, 16'hFFFF);
        end
        2: begin
          write_reg(ppss_pkg::RegSustain, ppss_pkg::SustainReset);
          write_reg(ppss_pkg::RegDamping, ppss_pkg::DampingReset);
          // unused indexes must leave both registers alone
          write_reg(RegUnusedLo, 16'h1234);
          write_reg(RegUnusedHi, 16'hFFFF);
        end
        default: begin
          write_reg(ppss_pkg::RegSustain,
                    ppss_pkg::CfgW'(($urandom_range(0, 3) == 0) ? 32'hFFFF : $urandom));
          write_reg(ppss_pkg::RegDamping, ppss_pkg::CfgW'($urandom));
        end
      endcase
      if (seg == 3) hold_token++;
      for (int k = 0; k < 150; k++) item_q.insert(item_q.size(), random_item());
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (sample_q.size() != 0) begin
      errors++;
      if (errors <= 10) $display("%0d expected samples never arrived", sample_q.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
